@@ rtl/window_spike_rejector_macros.svh @@
// Assertion macros for the window spike rejector RTL.
// Assumes clk_i and rst_ni are visible in the scope that uses them.
`ifndef WINDOW_SPIKE_REJECTOR_MACROS_SVH
`define WINDOW_SPIKE_REJECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSR_ASSERT(lbl, prop, msg)
`define WSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/wsr_pkg.sv @@
// Shared types and constants for the window spike rejector.
// No dependencies.
package wsr_pkg;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DEPTH_DEF = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;
endpackage

@@ rtl/window_spike_rejector.sv @@
// While filling, an accepted beat goes from ST_IDLE to ST_FIN; once full it passes
// through ST_SCAN and ST_DRAIN first, and ST_FIN waits while a held result is stalled.
// The scan uses the single compare unit, reading one window entry per cycle.
// Next beat is taken once the result sits in the output register.
// Reset: async active low; clears control, threshold and slot 0; no memory clear pass.
// Depends on wsr_pkg, wsr_window_mem, wsr_diff_unit and the macros header.
`include "window_spike_rejector_macros.svh"

module window_spike_rejector #(
  parameter int unsigned DEPTH = wsr_pkg::DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             threshold_we_i,
  input  wsr_pkg::sample_t threshold_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wsr_pkg::sample_t sample_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             anomaly_o,
  output wsr_pkg::sample_t newest_stored_o
);
  import wsr_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e          state_q;
  sample_t         thr_q;
  sample_t         sample_q;
  sample_t         slot0_q;
  logic [CntW-1:0] fill_cnt_q;
  logic [AW-1:0]   wp_q;
  logic [AW-1:0]   rd_idx_q;
  logic            cmp_en_q;
  logic            out_valid_q;
  logic            anomaly_q;
  sample_t         newest_q;

  logic    in_acc;
  logic    full;
  logic    out_free;
  logic    push_en;
  logic    mem_we;
  logic    mem_re;
  sample_t rdata;
  logic    hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign full       = (fill_cnt_q == CntW'(DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign push_en    = !full || !hit;
  assign mem_we     = (state_q == ST_FIN) && out_free && push_en;
  assign mem_re     = (state_q == ST_SCAN);

  wsr_window_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wp_q),
    .wdata_i(sample_q),
    .re_i   (mem_re),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  wsr_diff_unit u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (in_acc),
    .en_i       (cmp_en_q),
    .sample_i   (sample_q),
    .stored_i   (rdata),
    .threshold_i(thr_q),
    .hit_o      (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      sample_q    <= '0;
      slot0_q     <= '0;
      fill_cnt_q  <= '0;
      wp_q        <= '0;
      rd_idx_q    <= '0;
      cmp_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
      anomaly_q   <= 1'b0;
      newest_q    <= '0;
    end else begin
      if (threshold_we_i) begin
        thr_q <= threshold_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      cmp_en_q <= (state_q == ST_SCAN);

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q <= sample_i;
            rd_idx_q <= '0;
            state_q  <= full ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          if (rd_idx_q == AW'(DEPTH - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            anomaly_q   <= full && hit;
            if (push_en) begin
              wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
              if (!full) begin
                fill_cnt_q <= fill_cnt_q + 1'b1;
              end
            end
            if (push_en && (full || (fill_cnt_q == CntW'(DEPTH - 1)))) begin
              slot0_q  <= sample_q;
              newest_q <= sample_q;
            end else begin
              newest_q <= slot0_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign anomaly_o       = anomaly_q;
  assign newest_stored_o = newest_q;

  `WSR_ASSERT(a_fill_bounded, fill_cnt_q <= CntW'(DEPTH), "fill count above depth")
  `WSR_ASSERT(a_scan_when_full, (state_q != ST_SCAN) || full, "scan while window not full")
  `WSR_ASSERT(a_slot0_zero_filling, full || (slot0_q == '0), "slot 0 set before window full")
  `WSR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "idle after accept")
  `WSR_ASSERT(a_no_anomaly_filling, !(mem_we && !full && hit && !push_en), "fill beat dropped")
endmodule

@@ rtl/wsr_window_mem.sv @@
// Sample window storage: ring buffer, one write and one registered read port.
// Depends on wsr_pkg.
module wsr_window_mem #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wsr_pkg::sample_t         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output wsr_pkg::sample_t         rdata_o
);
  import wsr_pkg::*;

  sample_t mem_q [DEPTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/wsr_diff_unit.sv @@
// Shared compare unit: |sample - stored| > threshold, accumulated into a sticky hit.
// Depends on wsr_pkg.
module wsr_diff_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             en_i,
  input  wsr_pkg::sample_t sample_i,
  input  wsr_pkg::sample_t stored_i,
  input  wsr_pkg::sample_t threshold_i,
  output logic             hit_o
);
  import wsr_pkg::*;

  sample_t diff_ab;
  sample_t diff_ba;
  sample_t abs_diff;
  logic    exceed;
  logic    hit_q;

  assign diff_ab  = sample_i - stored_i;
  assign diff_ba  = stored_i - sample_i;
  assign abs_diff = (sample_i >= stored_i) ? diff_ab : diff_ba;
  assign exceed   = abs_diff > threshold_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (clr_i) begin
      hit_q <= 1'b0;
    end else if (en_i && exceed) begin
      hit_q <= 1'b1;
    end
  end

  assign hit_o = hit_q;
endmodule

@@ tb/tb_window_spike_rejector.sv @@
// Self-checking testbench for window_spike_rejector: directed table, then random beats.
// Predicts each result or takes it from the directed table, and checks the outputs field by field.
// Depends on wsr_pkg and the window_spike_rejector RTL.
`timescale 1ns / 100ps

module tb_window_spike_rejector;
  import wsr_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned BEATS_PER_PHASE = 316;

  typedef struct packed {
    logic    anomaly;
    sample_t newest_stored;
  } verdict_t;

  typedef enum logic {ROW_SAMPLE, ROW_THRESHOLD} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    sample_t   value;
    logic      typed;
    verdict_t  verdict;
  } stim_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    threshold_we_i = 1'b0;
  sample_t threshold_i = '0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  sample_t sample_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  logic    anomaly_o;
  sample_t newest_stored_o;

  sample_t     win_model [DEPTH];
  int unsigned stored_cnt = 0;
  sample_t     thr_model = '0;

  verdict_t  pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  window_spike_rejector #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .threshold_we_i (threshold_we_i),
    .threshold_i    (threshold_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .anomaly_o      (anomaly_o),
    .newest_stored_o(newest_stored_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb_window_spike_rejector failed");
    $finish;
  end

  function automatic verdict_t predict_window_step(sample_t s);
    verdict_t   v;
    logic [16:0] diff;
    v.anomaly = 1'b0;
    if (stored_cnt < DEPTH) begin
      win_model[DEPTH-1-stored_cnt] = s;
      stored_cnt++;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        diff = (s >= win_model[i]) ? {1'b0, s} - {1'b0, win_model[i]}
                                   : {1'b0, win_model[i]} - {1'b0, s};
        if (diff > {1'b0, thr_model}) v.anomaly = 1'b1;
      end
      if (!v.anomaly) begin
        for (int i = DEPTH - 1; i > 0; i--) win_model[i] = win_model[i-1];
        win_model[0] = s;
      end
    end
    v.newest_stored = win_model[0];
    return v;
  endfunction

  function automatic stim_row_t mk_row(row_kind_e kind, sample_t value, logic typed,
                                       logic anomaly, sample_t newest);
    stim_row_t r;
    r.kind = kind;
    r.value = value;
    r.typed = typed;
    r.verdict.anomaly = anomaly;
    r.verdict.newest_stored = newest;
    return r;
  endfunction

  // Mostly samples close to the stored window, plus noise, rail values and
  // samples right at or one past the threshold from slot 0.
  function automatic sample_t pick_sample();
    int r;
    int span;
    int center;
    int val;
    r = $urandom_range(99);
    span = (thr_model > 2047) ? 2047 : int'(thr_model);
    center = int'(win_model[$urandom_range(DEPTH - 1)]);
    if (r < 70) begin
      val = center + int'($urandom_range(span + span / 4 + 1)) * ($urandom_range(1) ? 1 : -1);
    end else if (r < 88) begin
      val = $urandom_range(65535);
    end else if (r < 94) begin
      val = $urandom_range(1) ? 65535 : 0;
    end else begin
      center = int'(win_model[0]);
      val = center + ($urandom_range(1) ? 1 : -1) *
            (int'(thr_model) + int'($urandom_range(1)));
    end
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    return sample_t'(val);
  endfunction

  task automatic send_sample(sample_t s, logic typed, verdict_t typed_v);
    verdict_t v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    v = predict_window_step(s);
    pending_results.push_back(typed ? typed_v : v);
  endtask

  // Drains every outstanding beat before touching the register.
  task automatic write_threshold(sample_t t);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    threshold_we_i <= 1'b1;
    threshold_i <= t;
    @(posedge clk_i);
    threshold_we_i <= 1'b0;
    thr_model = t;
  endtask

  always @(posedge clk_i) begin
    verdict_t exp_v;
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: anomaly %0b newest_stored %h", anomaly_o, newest_stored_o);
        mismatch_count++;
      end else begin
        exp_v = pending_results.pop_front();
        if (anomaly_o !== exp_v.anomaly) begin
          $error("anomaly: expected %0b, actual %0b", exp_v.anomaly, anomaly_o);
          mismatch_count++;
        end
        if (newest_stored_o !== exp_v.newest_stored) begin
          $error("newest_stored: expected %h, actual %h", exp_v.newest_stored,
                 newest_stored_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    sample_t thr;

    foreach (win_model[i]) win_model[i] = '0;

    // fill phase: no flag, slot 0 stays zero until the last fill beat
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h8000, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h0001, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h7FFF, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'hFFFE, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h5555, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'hAAAA, 1'b1, 1'b0, 16'hAAAA));
    // reset threshold of zero rejects against a spread window
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'hAAAA, 1'b1, 1'b1, 16'hAAAA));
    // full-scale difference equal to threshold is accepted
    directed_rows.push_back(mk_row(ROW_THRESHOLD, 16'hFFFF, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF));
    directed_rows.push_back(mk_row(ROW_THRESHOLD, 16'hFFFE, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h0000, 1'b1, 1'b1, 16'hFFFF));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
    directed_rows.push_back(mk_row(ROW_THRESHOLD, 16'h8000, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h8000, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_THRESHOLD, 16'hFFFF, 1'b0, 1'b0, 16'h0000));
    repeat (DEPTH) directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h4000, 1'b0, 1'b0, 16'h0000));
    // boundary: difference equal to threshold passes, one more fails
    directed_rows.push_back(mk_row(ROW_THRESHOLD, 16'h0010, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h4010, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h3FF0, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h3FFF, 1'b0, 1'b0, 16'h0000));
    directed_rows.push_back(mk_row(ROW_SAMPLE, 16'h4000, 1'b0, 1'b0, 16'h0000));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 55;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_THRESHOLD) begin
        write_threshold(directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].verdict);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: thr = sample_t'($urandom_range(255, 1));
        1: thr = '0;
        2: thr = sample_t'($urandom_range(4095, 256));
        3: thr = sample_t'($urandom_range(1023, 16));
        4: thr = sample_t'($urandom_range(65535));
        default: thr = 16'hFFFF;
      endcase
      write_threshold(thr);
      repeat (BEATS_PER_PHASE) send_sample(pick_sample(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (2 * DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_window_spike_rejector passed");
    end else begin
      $display("tb_window_spike_rejector failed");
    end
    $finish;
  end

endmodule
